[src/sap_pkg.sv]
// shared constants and register codes for the spatial attenuation and pan block
package sap_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int LIM_W     = 16;
  localparam int VOL_W     = 8;
  localparam int GAIN_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [VOL_W-1:0] VOL_FULL     = VOL_W'(128);
  localparam logic [VOL_W-1:0] MASTER_RESET = VOL_W'(128);
  localparam logic [VOL_W-1:0] SFX_RESET    = VOL_W'(100);
  localparam logic [GAIN_W-1:0] GAIN_SCALE  = GAIN_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASTER = 2'd0,
    CFG_SFX    = 2'd1
  } cfg_index_t;

endpackage

[src/sap_in_if.sv]
// input channel: listener and source positions with range limit
interface sap_in_if #(
  parameter int COORD_BITS = sap_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ear_x;
  logic signed [COORD_BITS-1:0] ear_y;
  logic signed [COORD_BITS-1:0] emit_x;
  logic signed [COORD_BITS-1:0] emit_y;
  logic [sap_pkg::LIM_W-1:0]    range_limit;

  modport source (output valid, ear_x, ear_y, emit_x, emit_y, range_limit,
                  input ready);
  modport sink   (input valid, ear_x, ear_y, emit_x, emit_y, range_limit,
                  output ready);
endinterface

[src/sap_out_if.sv]
// output channel: voice volume and speaker gains
interface sap_out_if;
  logic                       valid;
  logic                       ready;
  logic [sap_pkg::VOL_W-1:0]  voice_volume;
  logic [sap_pkg::GAIN_W-1:0] left_gain;
  logic [sap_pkg::GAIN_W-1:0] right_gain;

  modport source (output valid, voice_volume, left_gain, right_gain, input ready);
  modport sink   (input valid, voice_volume, left_gain, right_gain, output ready);
endinterface

[src/sap_cfg_if.sv]
// configuration write channel
interface sap_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sap_pkg::CFG_IDX_W-1:0] index;
  logic [sap_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/sap_front.sv]
// front end: accepts beats, forms offsets, squared distance and effective volume
module sap_front #(
  parameter int COORD_BITS = sap_pkg::COORD_BITS_DEF,
  parameter int IW         = 3 * (COORD_BITS + 1) + 1 + sap_pkg::LIM_W + sap_pkg::VOL_W
) (
  input  logic          clk,
  input  logic          rst,
  sap_in_if.sink        item,
  sap_cfg_if.sink       cfg,
  output logic          fo_valid,
  input  logic          fo_ready,
  output logic [IW-1:0] fo_data
);
  import sap_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int NW = 2 * DW;

  logic [VOL_W-1:0] main_volume;
  logic [VOL_W-1:0] sfx_group_volume;

  logic [2*VOL_W-1:0] vol_prod;
  logic [VOL_W:0]     eff_raw;
  logic [VOL_W-1:0]   eff_sat;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [LIM_W-1:0]     lim_fix;

  logic             s1_valid;
  logic [DW-1:0]    s1_adx;
  logic [DW-1:0]    s1_ady;
  logic             s1_neg;
  logic [LIM_W-1:0] s1_lim;
  logic [VOL_W-1:0] s1_eff;

  logic             s2_valid;
  logic [NW-1:0]    s2_n;
  logic [DW-1:0]    s2_adx;
  logic             s2_neg;
  logic [LIM_W-1:0] s2_lim;
  logic [VOL_W-1:0] s2_eff;

  logic          adv;
  logic [NW-1:0] sq_x;
  logic [NW-1:0] sq_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_volume      <= MASTER_RESET;
      sfx_group_volume <= SFX_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MASTER: main_volume      <= cfg.data;
        CFG_SFX:    sfx_group_volume <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective volume saturates at full scale for oversized register values
  assign vol_prod = main_volume * sfx_group_volume;
  assign eff_raw  = vol_prod[2*VOL_W-1:7];
  assign eff_sat  = (eff_raw > {1'b0, VOL_FULL}) ? VOL_FULL : eff_raw[VOL_W-1:0];

  assign dx = $signed({item.emit_x[COORD_BITS-1], item.emit_x})
            - $signed({item.ear_x[COORD_BITS-1], item.ear_x});
  assign dy = $signed({item.emit_y[COORD_BITS-1], item.emit_y})
            - $signed({item.ear_y[COORD_BITS-1], item.ear_y});
  assign lim_fix = (item.range_limit == '0) ? LIM_W'(1) : item.range_limit;

  assign adv        = !s2_valid || fo_ready;
  assign item.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item.valid;
      s2_valid <= s1_valid;
    end
  end

  assign sq_x = s1_adx * s1_adx;
  assign sq_y = s1_ady * s1_ady;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_adx <= dx[DW-1] ? DW'(-dx) : DW'(dx);
      s1_ady <= dy[DW-1] ? DW'(-dy) : DW'(dy);
      s1_neg <= dx[DW-1];
      s1_lim <= lim_fix;
      s1_eff <= eff_sat;
      s2_n   <= sq_x + sq_y;
      s2_adx <= s1_adx;
      s2_neg <= s1_neg;
      s2_lim <= s1_lim;
      s2_eff <= s1_eff;
    end
  end

  assign fo_valid = s2_valid;
  assign fo_data  = {s2_n, s2_adx, s2_neg, s2_lim, s2_eff};

endmodule

[src/sap_queue.sv]
// short queue between front and back ends
module sap_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  import sap_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = count != CW'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

[src/sap_back.sv]
// back end: pipelined root, ratio and pan dividers, volume and gain products
module sap_back #(
  parameter int COORD_BITS = sap_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sap_pkg::FRAC_BITS_DEF,
  parameter int IW         = 3 * (COORD_BITS + 1) + 1 + sap_pkg::LIM_W + sap_pkg::VOL_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  logic [IW-1:0]              q_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sap_pkg::VOL_W-1:0]  voice_volume,
  output logic [sap_pkg::GAIN_W-1:0] left_gain,
  output logic [sap_pkg::GAIN_W-1:0] right_gain
);
  import sap_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int P   = FRAC_BITS - 1;
  localparam int DW  = COORD_BITS + 1;
  localparam int NW  = 2 * DW;
  localparam int RS  = DW + 8;
  localparam int RMW = RS + 2;
  localparam int T   = RS + F + 1;

  logic adv;

  // carried along the whole pipeline
  logic             v     [0:T];
  logic [DW-1:0]    adx_a [0:T];
  logic             neg_a [0:T];
  logic [LIM_W-1:0] lim_a [0:T];
  logic [VOL_W-1:0] eff_a [0:T];

  // root stages
  logic [NW-1:0]  rn [0:RS];
  logic [RMW-1:0] rr [0:RS];
  logic [RS-1:0]  rq [0:RS];

  // ratio and pan divider stages
  logic [LIM_W-1:0] dr   [0:F];
  logic [F-1:0]     dq   [0:F];
  logic [F-1:0]     dfb  [0:F];
  logic             dsat [0:F];
  logic [LIM_W-1:0] pr   [0:F];
  logic [P-1:0]     pq   [0:F];
  logic             psat [0:F];

  logic [RS-1:0] root_q;

  assign adv     = !v[T] || out_ready;
  assign q_ready = adv;

  assign v[0]     = q_valid;
  assign eff_a[0] = q_data[VOL_W-1:0];
  assign lim_a[0] = q_data[VOL_W+LIM_W-1:VOL_W];
  assign neg_a[0] = q_data[VOL_W+LIM_W];
  assign adx_a[0] = q_data[VOL_W+LIM_W+DW:VOL_W+LIM_W+1];
  assign rn[0]    = q_data[IW-1:IW-NW];
  assign rr[0]    = '0;
  assign rq[0]    = '0;

  for (genvar s = 0; s < T; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        adx_a[s+1] <= adx_a[s];
        neg_a[s+1] <= neg_a[s];
        lim_a[s+1] <= lim_a[s];
        eff_a[s+1] <= eff_a[s];
      end
    end
  end

  // one root digit per stage; radicand bits shift out the top, zero pairs follow
  for (genvar i = 0; i < RS; i++) begin : g_root
    logic [RMW-1:0] remx;
    logic [RMW-1:0] trial;
    logic           take;
    assign remx  = {rr[i][RMW-3:0], rn[i][NW-1:NW-2]};
    assign trial = RMW'({rq[i], 2'b01});
    assign take  = remx >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        rn[i+1] <= rn[i] << 2;
        rr[i+1] <= take ? remx - trial : remx;
        rq[i+1] <= {rq[i][RS-2:0], take};
      end
    end
  end

  assign root_q  = rq[RS];
  assign dsat[0] = 32'(root_q[RS-1:8]) >= 32'(lim_a[RS]);
  assign dr[0]   = LIM_W'(root_q[RS-1:8]);
  assign dq[0]   = '0;
  assign dfb[0]  = F'(root_q[7:0]) << (F - 8);
  assign psat[0] = 32'(adx_a[RS]) >= 32'(lim_a[RS]);
  assign pr[0]   = LIM_W'(adx_a[RS]);
  assign pq[0]   = '0;

  // one quotient bit per stage for the ratio, and for pan in the first P stages
  for (genvar j = 0; j < F; j++) begin : g_div
    logic [LIM_W:0] rt;
    logic           rge;
    logic [LIM_W:0] pt;
    logic           pge;
    assign rt  = {dr[j], dfb[j][F-1]};
    assign rge = rt >= {1'b0, lim_a[RS+j]};
    assign pt  = {pr[j], 1'b0};
    assign pge = pt >= {1'b0, lim_a[RS+j]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dr[j+1]   <= rge ? LIM_W'(rt - {1'b0, lim_a[RS+j]}) : LIM_W'(rt);
        dq[j+1]   <= {dq[j][F-2:0], rge};
        dfb[j+1]  <= dfb[j] << 1;
        dsat[j+1] <= dsat[j];
        psat[j+1] <= psat[j];
      end
    end
    if (j < P) begin : g_pan
      always_ff @(posedge clk) begin
        if (adv) begin
          pr[j+1] <= pge ? LIM_W'(pt - {1'b0, lim_a[RS+j]}) : LIM_W'(pt);
          pq[j+1] <= {pq[j][P-2:0], pge};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (adv) begin
          pr[j+1] <= pr[j];
          pq[j+1] <= pq[j];
        end
      end
    end
  end

  logic [F:0]         ratio;
  logic [F+VOL_W:0]   vol_p;
  logic [F-1:0]       mag;
  logic [F:0]         lnum;
  logic [F:0]         rnum;
  logic [F+GAIN_W:0]  lg_p;
  logic [F+GAIN_W:0]  rg_p;

  assign ratio = dsat[F] ? '0 : ((F+1)'(1) << F) - (F+1)'(dq[F]);
  assign vol_p = eff_a[T-1] * ratio;
  assign mag   = psat[F] ? (F'(1) << P) : F'(pq[F]);
  assign lnum  = neg_a[T-1] ? ((F+1)'(1) << P) + (F+1)'(mag)
                            : ((F+1)'(1) << P) - (F+1)'(mag);
  assign rnum  = neg_a[T-1] ? ((F+1)'(1) << P) - (F+1)'(mag)
                            : ((F+1)'(1) << P) + (F+1)'(mag);
  assign lg_p  = GAIN_SCALE * lnum;
  assign rg_p  = GAIN_SCALE * rnum;

  always_ff @(posedge clk) begin
    if (adv) begin
      voice_volume <= vol_p[F+VOL_W-1:F];
      left_gain    <= lg_p[F+GAIN_W-1:F];
      right_gain   <= rg_p[F+GAIN_W-1:F];
    end
  end

  assign out_valid = v[T];

endmodule

[src/spatial_attenuation_and_pan.sv]
// top level of the spatial attenuation and pan block
//
//   channel  dir  beat contents
//   item     in   ear_x/y, emit_x/y, range_limit
//   result   out  voice_volume, left_gain, right_gain
//   cfg      in   index, data (master and effect group volume)
//
// one beat per cycle on every channel while no stall holds it, one result per item
// the path runs through two front stages, the queue,
// COORD_BITS + 9 root digit stages, FRAC_BITS divider stages and the output register
// a stalled result holds the back pipeline; the front keeps filling the queue until it is full
// rst is synchronous, clears the pipeline and queue valids and sets the volume registers to their reset values
module spatial_attenuation_and_pan #(
  parameter int COORD_BITS = sap_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sap_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  sap_in_if.sink    item,
  sap_out_if.source result,
  sap_cfg_if.sink   cfg
);
  import sap_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int IW = 2 * DW + DW + 1 + LIM_W + VOL_W;

  logic          f_valid;
  logic          f_ready;
  logic [IW-1:0] f_data;
  logic          b_valid;
  logic          b_ready;
  logic [IW-1:0] b_data;

  sap_front #(.COORD_BITS(COORD_BITS), .IW(IW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg      (cfg),
    .fo_valid (f_valid),
    .fo_ready (f_ready),
    .fo_data  (f_data)
  );

  sap_queue #(.W(IW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  sap_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .IW(IW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (b_valid),
    .q_ready      (b_ready),
    .q_data       (b_data),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .voice_volume (result.voice_volume),
    .left_gain    (result.left_gain),
    .right_gain   (result.right_gain)
  );

endmodule

[tb/sv/spatial_attenuation_and_pan_checker.sv]
// result checker: predicts voice volume and speaker gains for each accepted item
`timescale 1ns / 100ps

module spatial_attenuation_and_pan_checker (
  input  logic       clk,
  input  logic       rst,
  sap_in_if.sink     item_mon,
  sap_out_if.sink    result_mon,
  sap_cfg_if.sink    cfg_mon,
  output int         fail_count,
  output int         pending_count
);
  import sap_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    logic [VOL_W-1:0]  vol;
    logic [GAIN_W-1:0] left;
    logic [GAIN_W-1:0] right;
  } voice_mix_t;

  logic [VOL_W-1:0] master_q, sfx_q;
  voice_mix_t       mix_queue[$];

  // floor(sqrt(n) * 256) by restoring digit recurrence
  function automatic logic [63:0] dist_q8(input logic [63:0] n);
    logic [63:0] rem, root, trial, pair;
    rem  = 0;
    root = 0;
    for (int i = 31; i >= -8; i--) begin
      pair  = (i >= 0) ? ((n >> (2 * i)) & 64'd3) : 64'd0;
      rem   = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic voice_mix_t mix_for(
    input logic signed [15:0] lx, ly, sx, sy,
    input logic [15:0] lim_in,
    input logic [VOL_W-1:0] mv, sv
  );
    logic signed [17:0] dx, dy;
    logic [63:0] adx, ady, lim, one, half, d, q, ratio, eff, mag, lnum, rnum;
    voice_mix_t r;
    dx   = 18'(sx) - 18'(lx);
    dy   = 18'(sy) - 18'(ly);
    adx  = (dx < 0) ? 64'(-dx) : 64'(dx);
    ady  = (dy < 0) ? 64'(-dy) : 64'(dy);
    lim  = (lim_in == 0) ? 64'd1 : 64'(lim_in);
    one  = 64'd1 << FRAC;
    half = 64'd1 << (FRAC - 1);
    d     = dist_q8(adx * adx + ady * ady);
    q     = (d << FRAC) / (lim << 8);
    ratio = (q >= one) ? 64'd0 : one - q;
    eff   = (64'(mv) * 64'(sv)) >> 7;
    if (eff > 128) eff = 128;
    mag = (adx << (FRAC - 1)) / lim;
    if (mag > half) mag = half;
    lnum = (dx < 0) ? half + mag : half - mag;
    rnum = (dx < 0) ? half - mag : half + mag;
    r.vol   = VOL_W'((eff * ratio) >> FRAC);
    r.left  = GAIN_W'((64'd255 * lnum) >> FRAC);
    r.right = GAIN_W'((64'd255 * rnum) >> FRAC);
    return r;
  endfunction

  assign pending_count = mix_queue.size();

  always @(posedge clk) begin
    voice_mix_t want;
    int         errs;
    errs = 0;
    if (rst) begin
      master_q <= MASTER_RESET;
      sfx_q    <= SFX_RESET;
      mix_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_MASTER) master_q <= cfg_mon.data;
        else if (cfg_mon.index == CFG_SFX) sfx_q <= cfg_mon.data;
      end
      if (item_mon.valid && item_mon.ready)
        mix_queue.push_back(mix_for(item_mon.ear_x, item_mon.ear_y,
                                    item_mon.emit_x, item_mon.emit_y,
                                    item_mon.range_limit, master_q, sfx_q));
      if (result_mon.valid && result_mon.ready) begin
        if (mix_queue.size() == 0) begin
          $error("result beat with no item outstanding");
          errs++;
        end else begin
          want = mix_queue.pop_front();
          if (result_mon.voice_volume !== want.vol) begin
            $error("voice_volume expected %0d got %0d", want.vol, result_mon.voice_volume);
            errs++;
          end
          if (result_mon.left_gain !== want.left) begin
            $error("left_gain expected %0d got %0d", want.left, result_mon.left_gain);
            errs++;
          end
          if (result_mon.right_gain !== want.right) begin
            $error("right_gain expected %0d got %0d", want.right, result_mon.right_gain);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

[tb/sv/spatial_attenuation_and_pan_test.sv]
// top of the spatial attenuation and pan testbench: stimulus, pacing and verdict
`timescale 1ns / 100ps

module spatial_attenuation_and_pan_test;
  import sap_pkg::*;

  localparam int LATENCY = COORD_BITS_DEF + FRAC_BITS_DEF + 13;

  logic clk;
  logic rst;
  int   fail_count, pending_count;
  int   send_idle_pct, recv_idle_pct;
  bit   recv_hold;

  sap_in_if  item_ch ();
  sap_out_if result_ch ();
  sap_cfg_if cfg_ch ();

  spatial_attenuation_and_pan i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source),
    .cfg    (cfg_ch.sink)
  );

  spatial_attenuation_and_pan_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .item_mon      (item_ch.sink),
    .result_mon    (result_ch.sink),
    .cfg_mon       (cfg_ch.sink),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver pacing, with a long hold-off when asked
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold) begin
        result_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one edge first so the last accepted beat is already counted
  task automatic drain_results();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_voice(input logic signed [15:0] lx, ly, sx, sy,
                            input logic [15:0] lim);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.ear_x       <= lx;
    item_ch.ear_y       <= ly;
    item_ch.emit_x      <= sx;
    item_ch.emit_y      <= sy;
    item_ch.range_limit <= lim;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic send_random_voice();
    logic signed [15:0] lx, ly;
    logic [15:0] lim;
    lx = 16'($urandom);
    ly = 16'($urandom);
    case ($urandom_range(3))
      0: lim = 16'($urandom);
      1: lim = 16'($urandom_range(64));
      default: lim = 16'($urandom_range(4000));
    endcase
    if ($urandom_range(3) == 0)
      send_voice(lx, ly, 16'($urandom), 16'($urandom), lim);
    else
      // nearby sources mostly give nonzero volume and partial pan
      send_voice(lx, ly, lx + 16'($signed($urandom_range(2 * lim) - lim)),
                 ly + 16'($signed($urandom_range(lim) - lim / 2)), lim);
  endtask

  initial begin
    logic [7:0] vols[6] = '{8'd0, 8'd128, 8'd255, 8'd64, 8'd129, 8'd1};
    rst = 1'b1;
    recv_hold = 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 81;
    item_ch.valid = 1'b0;
    item_ch.ear_x = '0;
    item_ch.ear_y = '0;
    item_ch.emit_x = '0;
    item_ch.emit_y = '0;
    item_ch.range_limit = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MASTER;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset volumes, extremes, zero range, source at listener
    send_voice(0, 0, 0, 0, 100);
    send_voice(-32768, -32768, 32767, 32767, 65535);
    send_voice(32767, 32767, -32768, -32768, 65535);
    send_voice(10, 20, 10, 20, 0);
    send_voice(0, 0, 1, 0, 0);
    send_voice(0, 0, -1, 0, 1);
    send_voice(0, 0, 50, 0, 100);
    send_voice(0, 0, -50, 0, 100);
    send_voice(0, 0, 3, 4, 10);
    send_voice(0, 0, 0, 100, 100);
    send_voice(0, 0, 100, 0, 100);
    send_voice(-32768, 0, 32767, 0, 1);
    send_voice(0, 0, 0, 0, 65535);
    send_voice(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA);
    item_ch.valid <= 1'b0;
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MASTER, vols[ph]);
      write_reg(CFG_SFX, vols[(ph + 2) % 6]);
      if (ph == 2) begin
        send_idle_pct = 81;
        recv_idle_pct = 11;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 1) recv_hold = 1'b1;
      for (int n = 0; n < 256; n++) send_random_voice();
      item_ch.valid <= 1'b0;
      drain_results();
    end
    write_reg(CFG_MASTER, 8'd128);
    write_reg(CFG_SFX, 8'd128);
    for (int n = 0; n < 20; n++) send_random_voice();
    item_ch.valid <= 1'b0;
    drain_results();

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

[filelist.f]
src/sap_pkg.sv
src/sap_in_if.sv
src/sap_out_if.sv
src/sap_cfg_if.sv
src/sap_front.sv
src/sap_queue.sv
src/sap_back.sv
src/spatial_attenuation_and_pan.sv
tb/sv/spatial_attenuation_and_pan_checker.sv
tb/sv/spatial_attenuation_and_pan_test.sv
